@@ sv/bra_pkg.sv @@
// bra_pkg: codes, field widths and state type of the banker's allocator
// depends on nothing; every other file of the allocator imports it
`timescale 1ns / 1ps
`default_nettype none

package bra_pkg;

	// fixed widths of the item fields
	localparam int MODE_W     = 3;
	localparam int PROC_W     = 3;
	localparam int AMOUNT_W   = 8;
	localparam int REASON_W   = 3;
	localparam int MAX_LANES  = 4;

	// configuration register widths and apb port
	localparam int PROCS_CFG_W = 4;
	localparam int RES_CFG_W   = 3;
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	// register index, taken from paddr[2]
	localparam logic REG_PROCS     = 1'b0;
	localparam logic REG_RESOURCES = 1'b1;

	// operation codes of the mode field
	localparam logic [MODE_W-1:0] MODE_LOAD_AVAIL = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD_MAX   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_LOAD_HELD  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CHECK      = 3'd3;
	localparam logic [MODE_W-1:0] MODE_REQUEST    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_RELEASE    = 3'd5;

	// result reason codes
	localparam logic [REASON_W-1:0] RSN_OK         = 3'd0;
	localparam logic [REASON_W-1:0] RSN_OVER_NEED  = 3'd1;
	localparam logic [REASON_W-1:0] RSN_OVER_AVAIL = 3'd2;
	localparam logic [REASON_W-1:0] RSN_UNSAFE     = 3'd3;
	localparam logic [REASON_W-1:0] RSN_OVER_HELD  = 3'd4;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EXEC,
		ST_CHK_INIT,
		ST_CHK_ROW,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

@@ sv/bra_if.sv @@
// bra_req_if and bra_rsp_if: valid/ready channels of the allocator
// depends on bra_pkg for the field widths
`timescale 1ns / 1ps
`default_nettype none

interface bra_req_if;
	import bra_pkg::*;

	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [PROC_W-1:0]   process;
	logic [AMOUNT_W-1:0] amount_0;
	logic [AMOUNT_W-1:0] amount_1;
	logic [AMOUNT_W-1:0] amount_2;
	logic [AMOUNT_W-1:0] amount_3;

	modport source (output valid, mode, process, amount_0, amount_1, amount_2, amount_3,
		input ready);
	modport sink (input valid, mode, process, amount_0, amount_1, amount_2, amount_3,
		output ready);
endinterface

interface bra_rsp_if;
	import bra_pkg::*;

	logic                valid;
	logic                ready;
	logic                granted;
	logic [REASON_W-1:0] reason;

	modport source (output valid, granted, reason, input ready);
	modport sink (input valid, granted, reason, output ready);
endinterface

`default_nettype wire

@@ sv/bankers_resource_allocator_core.sv @@
// bankers_resource_allocator_core: banker's algorithm deadlock-avoidance allocator
// depends on bra_pkg and the channel interfaces in bra_if.sv
//
// One item is taken at a time; ready is low from acceptance until the result has been
// handed to the output register. Loads, releases and requests that fail a lane test go
// from fetch to execute to done. A safety check, and a request that passes its lane
// tests, runs a single row-compare unit that steps through one process row per cycle
// after an init state. It reads the maximum-claim and allocation memories at one row a
// cycle. The rows visited number about P*passes, at most P*P with P the number of processes
// in use. The output register lets the next item be accepted while a result still waits.
// Row memories carry per-row valid bits, so no clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module bankers_resource_allocator_core #(
	parameter int PROCESSES      = 8,
	parameter int RESOURCE_TYPES = 4,
	parameter int COUNT_BITS     = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	bra_req_if.sink                          req,
	bra_rsp_if.source                        rsp,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bra_pkg::APB_AW-1:0]  paddr,
	input  wire logic [bra_pkg::APB_DW-1:0]  pwdata,
	output logic      [bra_pkg::APB_DW-1:0]  prdata,
	output logic                             pready
);
	import bra_pkg::*;

	localparam int PW  = $clog2(PROCESSES);
	localparam int NPW = $clog2(PROCESSES + 1);
	localparam int RT  = RESOURCE_TYPES;
	localparam int CB  = COUNT_BITS;
	localparam int WW  = COUNT_BITS + 4;

	typedef logic [RT-1:0][CB-1:0] row_t;

	// configuration
	logic [PROCS_CFG_W-1:0] procs_q;
	logic [RES_CFG_W-1:0]   res_q;
	logic                   apb_wr;

	// sequencer
	state_t state_q, state_d;

	// item captured at acceptance
	logic [MODE_W-1:0] mode_q;
	logic [PROC_W-1:0] proc_q;
	row_t              amt_q;
	row_t              amt_in;

	// allocator state
	row_t                  avail_q;
	row_t                  sv_avail_q;
	row_t                  sv_held_q;
	logic [RT-1:0][WW-1:0] work_q;
	logic [PROCESSES-1:0]  done_q;
	logic [PW-1:0]         row_q;
	logic [NPW-1:0]        fin_q;
	logic                  prog_q;

	// row memories
	row_t                 max_mem [PROCESSES];
	row_t                 held_mem [PROCESSES];
	logic [PROCESSES-1:0] max_vld_q;
	logic [PROCESSES-1:0] held_vld_q;
	row_t                 max_rd_q;
	row_t                 held_rd_q;
	logic                 max_rd_vld_q;
	logic                 held_rd_vld_q;
	row_t                 max_row;
	row_t                 held_row;
	logic [PW-1:0]        rd_addr;

	// write ports
	logic mw_en;
	row_t mw_data;
	logic hw_en;
	logic hw_all;
	row_t hw_data;

	// decode and compare results
	logic [PW-1:0]  p_addr;
	logic           p_ok;
	logic [RT-1:0]  lane_en;
	logic [NPW-1:0] np_eff;
	logic [NPW-1:0] fin_nx;
	logic           over_need;
	logic           over_avail;
	logic           over_held;
	logic           req_pass;
	logic           fits;
	logic           take;
	logic           row_last;
	logic           chk_safe;
	logic           chk_fail;
	logic           chk_end;
	logic           out_free;

	// result registers
	logic                res_granted_q;
	logic [REASON_W-1:0] res_reason_q;
	logic                rsp_vld_q;
	logic                rsp_granted_q;
	logic [REASON_W-1:0] rsp_reason_q;

	// configuration port
	assign apb_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[2])
			REG_PROCS:     prdata = APB_DW'(procs_q);
			REG_RESOURCES: prdata = APB_DW'(res_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			procs_q <= PROCS_CFG_W'(8);
			res_q   <= RES_CFG_W'(4);
		end else if (apb_wr) begin
			unique case (paddr[2])
				REG_PROCS:     procs_q <= pwdata[PROCS_CFG_W-1:0];
				REG_RESOURCES: res_q   <= pwdata[RES_CFG_W-1:0];
				default:       ;
			endcase
		end
	end

	// lanes and processes in use, clamped
	always_comb begin
		for (int r = 0; r < RT; r++) begin
			lane_en[r] = (r == 0) || (32'(r) < 32'(res_q));
		end
		if (procs_q == '0) begin
			np_eff = NPW'(1);
		end else if (32'(procs_q) > 32'(PROCESSES)) begin
			np_eff = NPW'(PROCESSES);
		end else begin
			np_eff = NPW'(procs_q);
		end
	end

	// input amounts, low COUNT_BITS bits
	always_comb begin
		logic [MAX_LANES-1:0][AMOUNT_W-1:0] raw;
		raw = {req.amount_3, req.amount_2, req.amount_1, req.amount_0};
		for (int r = 0; r < RT; r++) begin
			amt_in[r] = CB'(raw[r]);
		end
	end

	assign p_addr = PW'(proc_q);
	assign p_ok   = 32'(proc_q) < 32'(PROCESSES);

	// rows never written read as zero
	assign max_row  = max_rd_vld_q ? max_rd_q : '0;
	assign held_row = held_rd_vld_q ? held_rd_q : '0;

	// lane tests of request and release
	always_comb begin
		over_need  = 1'b0;
		over_avail = 1'b0;
		over_held  = 1'b0;
		for (int r = 0; r < RT; r++) begin
			if (lane_en[r]) begin
				if (({1'b0, amt_q[r]} + {1'b0, held_row[r]}) > {1'b0, max_row[r]}) begin
					over_need = 1'b1;
				end
				if (amt_q[r] > avail_q[r]) over_avail = 1'b1;
				if (amt_q[r] > held_row[r]) over_held = 1'b1;
			end
		end
	end

	assign req_pass = p_ok && !over_need && !over_avail;

	// shared row-compare unit: need of the current row against work
	always_comb begin
		fits = 1'b1;
		for (int r = 0; r < RT; r++) begin
			if (lane_en[r] && ((WW+1)'(max_row[r]) >
				((WW+1)'(held_row[r]) + (WW+1)'(work_q[r])))) begin
				fits = 1'b0;
			end
		end
	end

	assign take     = fits && !done_q[row_q];
	assign fin_nx   = fin_q + NPW'(take);
	assign row_last = NPW'(row_q) == (np_eff - NPW'(1));
	assign chk_safe = fin_nx == np_eff;
	assign chk_fail = !chk_safe && row_last && !(prog_q || take);
	assign chk_end  = chk_safe || chk_fail;
	assign out_free = !rsp_vld_q || rsp.ready;

	// memory read address
	always_comb begin
		unique case (state_q)
			ST_CHK_INIT: rd_addr = '0;
			ST_CHK_ROW:  rd_addr = row_last ? '0 : row_q + PW'(1);
			default:     rd_addr = p_addr;
		endcase
	end

	// memory write requests
	always_comb begin
		mw_en   = 1'b0;
		hw_en   = 1'b0;
		hw_all  = 1'b0;
		mw_data = '0;
		hw_data = '0;
		for (int r = 0; r < RT; r++) begin
			if (lane_en[r]) mw_data[r] = amt_q[r];
		end
		if (state_q == ST_EXEC && p_ok) begin
			case (mode_q)
				MODE_LOAD_MAX: mw_en = 1'b1;
				MODE_LOAD_HELD: begin
					hw_en = 1'b1;
					hw_data = mw_data;
				end
				MODE_REQUEST: begin
					hw_en = !over_need && !over_avail;
					for (int r = 0; r < RT; r++) begin
						if (lane_en[r]) hw_data[r] = held_row[r] + amt_q[r];
					end
				end
				MODE_RELEASE: begin
					hw_en = !over_held;
					for (int r = 0; r < RT; r++) begin
						if (lane_en[r]) hw_data[r] = held_row[r] - amt_q[r];
					end
				end
				default: ;
			endcase
		end else if (state_q == ST_CHK_ROW && chk_fail && mode_q == MODE_REQUEST) begin
			// roll back the allocation row of a refused request
			hw_en   = 1'b1;
			hw_all  = 1'b1;
			hw_data = sv_held_q;
		end
	end

	// row memories: one write and one read address per cycle
	always_ff @(posedge clk) begin
		if (mw_en) begin
			for (int r = 0; r < RT; r++) begin
				if (lane_en[r] || !max_vld_q[p_addr]) max_mem[p_addr][r] <= mw_data[r];
			end
		end
		if (hw_en) begin
			for (int r = 0; r < RT; r++) begin
				if (hw_all || lane_en[r] || !held_vld_q[p_addr]) begin
					held_mem[p_addr][r] <= hw_data[r];
				end
			end
		end
		max_rd_q      <= max_mem[rd_addr];
		held_rd_q     <= held_mem[rd_addr];
		max_rd_vld_q  <= max_vld_q[rd_addr];
		held_rd_vld_q <= held_vld_q[rd_addr];
	end

	// row valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_vld_q  <= '0;
			held_vld_q <= '0;
		end else begin
			if (mw_en) max_vld_q[p_addr] <= 1'b1;
			if (hw_en) held_vld_q[p_addr] <= 1'b1;
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// next state and ready
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) state_d = ST_FETCH;
			end
			ST_FETCH: state_d = ST_EXEC;
			ST_EXEC: begin
				if (mode_q == MODE_CHECK || (mode_q == MODE_REQUEST && req_pass)) begin
					state_d = ST_CHK_INIT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_CHK_INIT: state_d = ST_CHK_ROW;
			ST_CHK_ROW: if (chk_end) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// available, work vector, finish flags and pass control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avail_q   <= '0;
			work_q    <= '0;
			done_q    <= '0;
			row_q     <= '0;
			fin_q     <= '0;
			prog_q    <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_EXEC: begin
					for (int r = 0; r < RT; r++) begin
						if (lane_en[r]) begin
							logic [CB:0] sum;
							sum = {1'b0, avail_q[r]} + {1'b0, amt_q[r]};
							if (mode_q == MODE_LOAD_AVAIL) begin
								avail_q[r] <= amt_q[r];
							end else if (mode_q == MODE_REQUEST && req_pass) begin
								avail_q[r] <= avail_q[r] - amt_q[r];
							end else if (mode_q == MODE_RELEASE && p_ok && !over_held) begin
								avail_q[r] <= sum[CB] ? '1 : sum[CB-1:0];
							end
						end
					end
				end
				ST_CHK_INIT: begin
					for (int r = 0; r < RT; r++) begin
						work_q[r] <= WW'(avail_q[r]);
					end
					done_q <= '0;
					row_q  <= '0;
					fin_q  <= '0;
					prog_q <= 1'b0;
				end
				ST_CHK_ROW: begin
					if (take) begin
						for (int r = 0; r < RT; r++) begin
							if (lane_en[r]) begin
								logic [WW:0] wsum;
								wsum = {1'b0, work_q[r]} + (WW+1)'(held_row[r]);
								work_q[r] <= wsum[WW] ? '1 : wsum[WW-1:0];
							end
						end
						done_q[row_q] <= 1'b1;
					end
					fin_q <= fin_nx;
					if (row_last) begin
						row_q  <= '0;
						prog_q <= 1'b0;
					end else begin
						row_q  <= row_q + PW'(1);
						prog_q <= prog_q || take;
					end
					if (chk_fail && mode_q == MODE_REQUEST) avail_q <= sv_avail_q;
				end
				default: ;
			endcase
			// output register
			if (state_q == ST_DONE && out_free) rsp_vld_q <= 1'b1;
			else if (rsp.ready) rsp_vld_q <= 1'b0;
		end
	end

	// item capture, rollback copies and result
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			mode_q <= req.mode;
			proc_q <= req.process;
			amt_q  <= amt_in;
		end
		if (state_q == ST_EXEC) begin
			case (mode_q)
				MODE_LOAD_AVAIL: begin
					res_granted_q <= 1'b1;
					res_reason_q  <= RSN_OK;
				end
				MODE_LOAD_MAX, MODE_LOAD_HELD: begin
					res_granted_q <= p_ok;
					res_reason_q  <= RSN_OK;
				end
				MODE_REQUEST: begin
					res_granted_q <= 1'b0;
					if (p_ok && over_need) begin
						res_reason_q <= RSN_OVER_NEED;
					end else if (p_ok && over_avail) begin
						res_reason_q <= RSN_OVER_AVAIL;
					end else begin
						res_reason_q <= RSN_OK;
					end
					sv_avail_q <= avail_q;
					sv_held_q  <= held_row;
				end
				MODE_RELEASE: begin
					if (p_ok && over_held) begin
						res_granted_q <= 1'b0;
						res_reason_q  <= RSN_OVER_HELD;
					end else begin
						res_granted_q <= p_ok;
						res_reason_q  <= RSN_OK;
					end
				end
				default: begin
					res_granted_q <= 1'b0;
					res_reason_q  <= RSN_OK;
				end
			endcase
		end
		if (state_q == ST_CHK_ROW && chk_end) begin
			res_granted_q <= chk_safe;
			res_reason_q  <= chk_safe ? RSN_OK : RSN_UNSAFE;
		end
		if (state_q == ST_DONE && out_free) begin
			rsp_granted_q <= res_granted_q;
			rsp_reason_q  <= res_reason_q;
		end
	end

	assign rsp.valid   = rsp_vld_q;
	assign rsp.granted = rsp_granted_q;
	assign rsp.reason  = rsp_reason_q;

endmodule

`default_nettype wire

@@ sv/bra_checker.sv @@
// bra_checker: port-level assertions for bankers_resource_allocator_core, with its bind
// depends on bra_pkg and on the top level's port names
`timescale 1ns / 1ps
`default_nettype none

module bra_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic                         granted,
	input wire logic [bra_pkg::REASON_W-1:0] reason
);
	import bra_pkg::*;

	logic       in_acc;
	logic       out_acc;
	logic [1:0] pend_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// items accepted whose result has not been taken yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= '0;
		else pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
	end

	// one item in work plus one result waiting, never more
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two items outstanding");

	// no result without an accepted item
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result shown with no item outstanding");

	// an accepted item keeps the block busy the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("ready high right after acceptance");

	// a granted result always carries reason ok
	a_granted_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && granted |-> reason == RSN_OK)
		else $error("granted result with a failure reason");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(granted) && $stable(reason))
		else $error("stalled result changed");

endmodule

bind bankers_resource_allocator_core bra_checker u_bra_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.granted   (rsp.granted),
	.reason    (rsp.reason)
);

`default_nettype wire

@@ sim/tb_bankers_resource_allocator_core.sv @@
// testbench for bankers_resource_allocator_core: random and directed items checked
// against a built-in banker's algorithm predictor; depends on bra_pkg and bra_if.sv
`timescale 1ns / 1ps

import bra_pkg::*;

localparam int PROC_ROWS = 8;
localparam int COUNT_MAX = 255;
localparam int WORK_MAX  = 4095;

// mode codes the block leaves unused
localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

typedef struct packed {
	logic [MODE_W-1:0]                   mode;
	logic [PROC_W-1:0]                   process;
	logic [MAX_LANES-1:0][AMOUNT_W-1:0]  amount;
} alloc_item_t;

typedef struct packed {
	logic                granted;
	logic [REASON_W-1:0] reason;
} alloc_result_t;

// allocation state predictor and queue of expected verdicts
class alloc_scoreboard;
	logic [AMOUNT_W-1:0] avail [MAX_LANES];
	logic [AMOUNT_W-1:0] max_claim [PROC_ROWS][MAX_LANES];
	logic [AMOUNT_W-1:0] held [PROC_ROWS][MAX_LANES];
	logic [PROCS_CFG_W-1:0] procs_reg;
	logic [RES_CFG_W-1:0] lanes_reg;
	alloc_result_t verdict_q[$];
	int mismatches;

	function new();
		procs_reg = 4'd8;
		lanes_reg = 3'd4;
		mismatches = 0;
		foreach (avail[r]) avail[r] = '0;
		foreach (max_claim[p, r]) begin
			max_claim[p][r] = '0;
			held[p][r] = '0;
		end
	endfunction

	function int used_procs();
		if (procs_reg < 1) return 1;
		if (procs_reg > PROC_ROWS) return PROC_ROWS;
		return procs_reg;
	endfunction

	function int used_lanes();
		if (lanes_reg < 1) return 1;
		if (lanes_reg > MAX_LANES) return MAX_LANES;
		return lanes_reg;
	endfunction

	function int need_of(int p, int r);
		return int'(max_claim[p][r]) - int'(held[p][r]);
	endfunction

	function int pending();
		return verdict_q.size();
	endfunction

	function void write_register(logic idx, logic [APB_DW-1:0] data);
		if (idx == REG_PROCS)
			procs_reg = data[PROCS_CFG_W-1:0];
		else
			lanes_reg = data[RES_CFG_W-1:0];
	endfunction

	// repeated passes over unfinished processes until all finish or none does
	function bit state_is_safe();
		int np, nr, finished, p, r;
		bit progress, fits;
		bit done [PROC_ROWS];
		int work [MAX_LANES];
		np = used_procs();
		nr = used_lanes();
		finished = 0;
		foreach (done[i]) done[i] = 1'b0;
		for (r = 0; r < MAX_LANES; r++) work[r] = avail[r];
		while (finished < np) begin
			progress = 1'b0;
			for (p = 0; p < np; p++) begin
				if (!done[p]) begin
					fits = 1'b1;
					for (r = 0; r < nr; r++)
						if (need_of(p, r) > work[r]) fits = 1'b0;
					if (fits) begin
						for (r = 0; r < nr; r++) begin
							work[r] = work[r] + held[p][r];
							if (work[r] > WORK_MAX) work[r] = WORK_MAX;
						end
						done[p] = 1'b1;
						progress = 1'b1;
						finished++;
					end
				end
			end
			if (!progress) return 1'b0;
		end
		return 1'b1;
	endfunction

	// apply one accepted item and queue its verdict
	function void note_item(alloc_item_t item);
		alloc_result_t res;
		logic [AMOUNT_W-1:0] saved_avail [MAX_LANES];
		logic [AMOUNT_W-1:0] saved_held [MAX_LANES];
		bit over_need, over_avail, over_held;
		int p, r, nr, sum;
		res.granted = 1'b0;
		res.reason = RSN_OK;
		p = item.process;
		nr = used_lanes();
		case (item.mode)
		MODE_LOAD_AVAIL: begin
			for (r = 0; r < nr; r++) avail[r] = item.amount[r];
			res.granted = 1'b1;
		end
		MODE_LOAD_MAX: begin
			for (r = 0; r < nr; r++) max_claim[p][r] = item.amount[r];
			res.granted = 1'b1;
		end
		MODE_LOAD_HELD: begin
			for (r = 0; r < nr; r++) held[p][r] = item.amount[r];
			res.granted = 1'b1;
		end
		MODE_CHECK: begin
			res.granted = state_is_safe();
			if (!res.granted) res.reason = RSN_UNSAFE;
		end
		MODE_REQUEST: begin
			over_need = 1'b0;
			over_avail = 1'b0;
			for (r = 0; r < nr; r++) begin
				if (int'(item.amount[r]) > need_of(p, r)) over_need = 1'b1;
				if (item.amount[r] > avail[r]) over_avail = 1'b1;
			end
			if (over_need) begin
				res.reason = RSN_OVER_NEED;
			end else if (over_avail) begin
				res.reason = RSN_OVER_AVAIL;
			end else begin
				// grant tentatively, roll back if the result is unsafe
				saved_avail = avail;
				saved_held = held[p];
				for (r = 0; r < nr; r++) begin
					avail[r] = avail[r] - item.amount[r];
					held[p][r] = held[p][r] + item.amount[r];
				end
				if (state_is_safe()) begin
					res.granted = 1'b1;
				end else begin
					avail = saved_avail;
					held[p] = saved_held;
					res.reason = RSN_UNSAFE;
				end
			end
		end
		MODE_RELEASE: begin
			over_held = 1'b0;
			for (r = 0; r < nr; r++)
				if (item.amount[r] > held[p][r]) over_held = 1'b1;
			if (over_held) begin
				res.reason = RSN_OVER_HELD;
			end else begin
				for (r = 0; r < nr; r++) begin
					sum = int'(avail[r]) + int'(item.amount[r]);
					avail[r] = (sum > COUNT_MAX) ? {AMOUNT_W{1'b1}} : sum[AMOUNT_W-1:0];
					held[p][r] = held[p][r] - item.amount[r];
				end
				res.granted = 1'b1;
			end
		end
		default: ;
		endcase
		verdict_q.push_back(res);
	endfunction

	// compare one accepted result with the oldest expected verdict
	function void check_result(logic granted, logic [REASON_W-1:0] reason);
		alloc_result_t exp_res;
		if (verdict_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: granted %0d reason %0d", granted, reason);
			return;
		end
		exp_res = verdict_q.pop_front();
		if (granted !== exp_res.granted || reason !== exp_res.reason) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result mismatch: expected granted %0d reason %0d, %s %0d reason %0d",
					exp_res.granted, exp_res.reason, "got granted", granted, reason);
		end
	endfunction
endclass

module tb_bankers_resource_allocator_core;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 80;
	localparam int PHASES        = 13;
	localparam int PHASE_ITEMS   = 100;
	localparam int MAX_GAP       = 18;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	bra_req_if req_ch();
	bra_rsp_if rsp_ch();

	alloc_scoreboard sb = new();
	int cycles = 0;
	bit no_idle = 1'b0;
	int hold_off = 0;

	bankers_resource_allocator_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic int draw_gap();
		if (no_idle) return 0;
		return $urandom_range(0, MAX_GAP);
	endfunction

	// offer one item after a random gap and wait until it is taken
	task automatic send_item(logic [MODE_W-1:0] mode, logic [PROC_W-1:0] proc,
		logic [AMOUNT_W-1:0] a0, logic [AMOUNT_W-1:0] a1,
		logic [AMOUNT_W-1:0] a2, logic [AMOUNT_W-1:0] a3);
		alloc_item_t item;
		int gap;
		item.mode = mode;
		item.process = proc;
		item.amount = {a3, a2, a1, a0};
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.mode <= mode;
		req_ch.process <= proc;
		req_ch.amount_0 <= a0;
		req_ch.amount_1 <= a1;
		req_ch.amount_2 <= a2;
		req_ch.amount_3 <= a3;
		req_ch.valid <= 1'b1;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note_item(item);
	endtask

	// stop offering and wait for every outstanding verdict
	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(logic idx, logic [APB_DW-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.write_register(idx, data);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// available vector plus a claim and allocation row for every process
	task automatic load_rows(int lim);
		logic [AMOUNT_W-1:0] m [MAX_LANES];
		logic [AMOUNT_W-1:0] h [MAX_LANES];
		int p, r;
		for (r = 0; r < MAX_LANES; r++) m[r] = AMOUNT_W'($urandom_range(lim / 2, lim));
		send_item(MODE_LOAD_AVAIL, 0, m[0], m[1], m[2], m[3]);
		for (p = 0; p < PROC_ROWS; p++) begin
			for (r = 0; r < MAX_LANES; r++) begin
				m[r] = AMOUNT_W'($urandom_range(0, lim));
				// now and then an allocation above the claim
				if ($urandom_range(0, 9) == 0)
					h[r] = AMOUNT_W'($urandom_range(0, lim));
				else
					h[r] = AMOUNT_W'($urandom_range(0, m[r]));
			end
			send_item(MODE_LOAD_MAX, PROC_W'(p), m[0], m[1], m[2], m[3]);
			send_item(MODE_LOAD_HELD, PROC_W'(p), h[0], h[1], h[2], h[3]);
		end
	endtask

	// one random operation, mostly well-formed for the current state
	task automatic random_op(int lim);
		logic [AMOUNT_W-1:0] a [MAX_LANES];
		logic [MODE_W-1:0] mode;
		int sel, p, r, top;
		sel = $urandom_range(0, 99);
		if ($urandom_range(0, 4) != 0)
			p = $urandom_range(0, sb.used_procs() - 1);
		else
			p = $urandom_range(0, PROC_ROWS - 1);
		for (r = 0; r < MAX_LANES; r++) a[r] = AMOUNT_W'($urandom_range(0, lim));
		if (sel < 40) begin
			mode = MODE_REQUEST;
			for (r = 0; r < MAX_LANES; r++) begin
				top = sb.need_of(p, r);
				if (top < 0) top = 0;
				if ($urandom_range(0, 3) != 0 && top > sb.avail[r]) top = sb.avail[r];
				a[r] = AMOUNT_W'($urandom_range(0, top));
			end
			if ($urandom_range(0, 7) == 0) begin
				r = $urandom_range(0, MAX_LANES - 1);
				a[r] = a[r] + AMOUNT_W'(1);
			end
		end else if (sel < 60) begin
			mode = MODE_RELEASE;
			for (r = 0; r < MAX_LANES; r++) a[r] = AMOUNT_W'($urandom_range(0, sb.held[p][r]));
			if ($urandom_range(0, 7) == 0) begin
				r = $urandom_range(0, MAX_LANES - 1);
				a[r] = a[r] + AMOUNT_W'(1);
			end
		end else if (sel < 75) begin
			mode = MODE_CHECK;
		end else if (sel < 85) begin
			mode = MODE_W'($urandom_range(MODE_LOAD_AVAIL, MODE_LOAD_HELD));
		end else begin
			// noise over the full field ranges
			mode = MODE_W'($urandom_range(0, 7));
			p = $urandom_range(0, PROC_ROWS - 1);
			for (r = 0; r < MAX_LANES; r++) a[r] = AMOUNT_W'($urandom_range(0, COUNT_MAX));
		end
		send_item(mode, PROC_W'(p), a[0], a[1], a[2], a[3]);
	endtask

	task automatic directed_items();
		send_item(MODE_CHECK, 0, 0, 0, 0, 0);
		send_item(MODE_LOAD_AVAIL, 0, 3, 3, 3, 3);
		send_item(MODE_LOAD_MAX, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_item(MODE_CHECK, 0, 0, 0, 0, 0);
		// over available only, then over need and over available together
		send_item(MODE_REQUEST, 0, 4, 0, 0, 0);
		send_item(MODE_REQUEST, 1, 5, 0, 0, 0);
		send_item(MODE_LOAD_MAX, 0, 5, 5, 5, 5);
		send_item(MODE_LOAD_HELD, 0, 2, 2, 2, 2);
		send_item(MODE_REQUEST, 0, 3, 3, 3, 3);
		send_item(MODE_RELEASE, 0, 6, 0, 0, 0);
		send_item(MODE_RELEASE, 0, 5, 5, 5, 5);
		// allocation above claim gives a negative need
		send_item(MODE_LOAD_HELD, 1, 200, 200, 200, 200);
		send_item(MODE_CHECK, 0, 0, 0, 0, 0);
		// release into a full available vector saturates
		send_item(MODE_LOAD_AVAIL, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_item(MODE_RELEASE, 1, 200, 200, 200, 200);
		// request that passes the lane tests but leaves the state unsafe
		send_item(MODE_LOAD_MAX, 0, 0, 0, 0, 0);
		send_item(MODE_LOAD_AVAIL, 0, 2, 2, 2, 2);
		send_item(MODE_LOAD_MAX, 2, 4, 4, 4, 4);
		send_item(MODE_LOAD_HELD, 2, 1, 1, 1, 1);
		send_item(MODE_LOAD_MAX, 3, 4, 4, 4, 4);
		send_item(MODE_LOAD_HELD, 3, 1, 1, 1, 1);
		send_item(MODE_REQUEST, 2, 2, 2, 2, 2);
		send_item(MODE_RELEASE, 2, 1, 1, 1, 1);
		// unused modes
		send_item(MODE_SPARE_A, 7, 8'hAA, 8'h55, 8'hAA, 8'h55);
		send_item(MODE_SPARE_B, 5, 8'h55, 8'hAA, 8'h55, 8'hAA);
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin : result_side
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap();
			if (hold_off > 0) begin
				gap = hold_off;
				hold_off = 0;
			end
			@(negedge clk);
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			sb.check_result(rsp_ch.granted, rsp_ch.reason);
		end
	end

	// reset, directed items, then random phases under changing settings
	initial begin : stimulus
		int ph, i, lim;
		logic [APB_DW-1:0] procs, lanes;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_LOAD_AVAIL;
		req_ch.process = '0;
		req_ch.amount_0 = '0;
		req_ch.amount_1 = '0;
		req_ch.amount_2 = '0;
		req_ch.amount_3 = '0;
		rsp_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed_items();

		for (ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			case (ph)
			0: begin
				procs = 8;
				lanes = 4;
			end
			1: begin
				procs = 1;
				lanes = 1;
			end
			2: begin
				procs = 0;
				lanes = 0;
			end
			3: begin
				procs = 15;
				lanes = 7;
			end
			default: begin
				procs = $urandom_range(1, 8);
				lanes = $urandom_range(1, 4);
			end
			endcase
			apb_write(REG_PROCS, procs);
			apb_write(REG_RESOURCES, lanes);
			no_idle = (ph % 4 == 1);
			case (ph % 5)
			0: lim = 3;
			1: lim = 15;
			2: lim = 255;
			3: lim = 7;
			default: lim = 63;
			endcase
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 50 == 0) load_rows(lim);
				// long receiver stall while items keep coming
				if (ph == 1 && i == 30) hold_off = 400;
				// sender pause until every verdict is back
				if (ph == 6 && i == 60) wait_drained();
				random_op(lim);
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ bankers_resource_allocator_core.f @@
sv/bra_pkg.sv
sv/bra_if.sv
sv/bankers_resource_allocator_core.sv
sv/bra_checker.sv
sim/tb_bankers_resource_allocator_core.sv
